// ----- hdl/tun_pkg.sv -----
// Shared types and constants for the triangle unit normal pipeline.
`default_nettype none
package tun_pkg;

  localparam int MAG_W  = 31;  // width of a scaled cross-product magnitude
  localparam int ROOT_W = 32;  // width of the integer square root
  localparam int SUM_W  = 64;  // width of the sum of squares
  localparam int SREM_W = 36;  // width of the square-root partial remainder

  // Side information that travels along with one triangle.
  typedef struct packed {
    logic                  deg;  // zero cross product
    logic [2:0]            neg;  // sign of each cross-product component
    logic [2:0][MAG_W-1:0] m;    // scaled magnitudes
  } flow_t;

endpackage
`default_nettype wire

// ----- hdl/tun_sqrt_cell.sv -----
// One cell of the square-root chain: settles one root bit per cell.
`default_nettype none
module tun_sqrt_cell (
  input  wire                              clk,
  input  wire                              en,
  input  wire  [tun_pkg::SUM_W-1:0]        s_in,
  input  wire  [tun_pkg::SREM_W-1:0]       rem_in,
  input  wire  [tun_pkg::ROOT_W-1:0]       root_in,
  input  wire  tun_pkg::flow_t             flow_in,
  output logic [tun_pkg::SUM_W-1:0]        s_out,
  output logic [tun_pkg::SREM_W-1:0]       rem_out,
  output logic [tun_pkg::ROOT_W-1:0]       root_out,
  output tun_pkg::flow_t                   flow_out
);

  logic [tun_pkg::SREM_W-1:0] rem_sh;
  logic [tun_pkg::SREM_W-1:0] trial;
  logic                       take;

  // Bring in the next two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {rem_in[tun_pkg::SREM_W-3:0], s_in[tun_pkg::SUM_W-1 -: 2]};
    trial  = tun_pkg::SREM_W'({root_in, 2'b01});
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_out    <= {s_in[tun_pkg::SUM_W-3:0], 2'b00};
      rem_out  <= take ? (rem_sh - trial) : rem_sh;
      root_out <= {root_in[tun_pkg::ROOT_W-2:0], take};
      flow_out <= flow_in;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tun_div_cell.sv -----
// One cell of the division chain: settles one quotient bit for all three lanes.
`default_nettype none
module tun_div_cell #(
  parameter int FRAC = 30
) (
  input  wire                                  clk,
  input  wire                                  en,
  input  wire  [tun_pkg::ROOT_W-1:0]           root_in,
  input  wire  [2:0][tun_pkg::ROOT_W-1:0]      rem_in,
  input  wire  [2:0][FRAC:0]                   num_in,
  input  wire  [2:0][FRAC:0]                   quo_in,
  input  wire  tun_pkg::flow_t                 flow_in,
  output logic [tun_pkg::ROOT_W-1:0]           root_out,
  output logic [2:0][tun_pkg::ROOT_W-1:0]      rem_out,
  output logic [2:0][FRAC:0]                   num_out,
  output logic [2:0][FRAC:0]                   quo_out,
  output tun_pkg::flow_t                       flow_out
);

  logic [2:0][tun_pkg::ROOT_W:0]   trial;
  logic [2:0]                      take;
  logic [2:0][tun_pkg::ROOT_W:0]   diff;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_in[i], num_in[i][FRAC]};
      take[i]  = (trial[i] >= {1'b0, root_in});
      diff[i]  = trial[i] - {1'b0, root_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_out <= root_in;
      flow_out <= flow_in;
      for (int i = 0; i < 3; i++) begin
        rem_out[i] <= take[i] ? diff[i][tun_pkg::ROOT_W-1:0]
                              : trial[i][tun_pkg::ROOT_W-1:0];
        num_out[i] <= {num_in[i][FRAC-1:0], 1'b0};
        quo_out[i] <= {quo_in[i][FRAC-1:0], take[i]};
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/triangle_unit_normal_core.sv -----
// Top level of the triangle unit normal pipeline.
`default_nettype none
// Takes one triangle (three vertices, signed fixed point) per transfer on the
// slave side and returns its unit normal, right-hand rule on the vertices in
// the order given, as three signed components with NORMAL_FRAC_BITS fraction
// bits, plus a degenerate flag for a zero cross product (normal then zero).
// The block is one pipeline: nine front stages (input, edges, products, cross
// product, magnitude, leading-bit search, scaling, squares, sum), a chain of
// 32 square-root cells, one numerator stage, a chain of NORMAL_FRAC_BITS+1
// divider cells and the output register. A new triangle is taken every cycle
// while the pipeline is not held. The whole pipeline holds only when the
// output register is full, not taken, and the last stage holds a result; an
// empty last stage never holds the pipeline.
module triangle_unit_normal_core #(
  parameter int COORD_WIDTH      = 24,
  parameter int NORMAL_FRAC_BITS = 30
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      s_tvalid,
  output logic                                     s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // third_x, third_y, third_z from the lowest bit up, zero padded to bytes
  input  wire  [((9*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
  output logic                                     m_tvalid,
  input  wire                                      m_tready,
  // normal_x, normal_y, normal_z from the lowest bit up
  output logic [95:0]                              m_tdata,
  // degenerate
  output logic [0:0]                               m_tuser
);

  localparam int W     = COORD_WIDTH;
  localparam int EW    = W + 1;
  localparam int PW    = 2 * EW;
  localparam int KW    = 2 * W + 3;
  localparam int LW    = $clog2(KW + 1);
  localparam int F     = NORMAL_FRAC_BITS;
  localparam int QW    = F + 1;
  localparam int NW    = 32 + F;
  localparam int NSQ   = tun_pkg::ROOT_W;
  localparam int DEPTH = 9 + NSQ + 1 + QW;
  localparam int MW    = tun_pkg::MAG_W;

  logic             en;
  logic [DEPTH-1:0] vld;
  logic             out_valid;

  // Advance everything unless a finished result would be overwritten.
  assign en       = !out_valid || m_tready || !vld[DEPTH-1];
  assign s_tready = en;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  // Front stages.
  logic signed [W-1:0]  crd [9];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [PW-1:0] pr [6];
  logic signed [KW-1:0] k [3];
  logic [KW-1:0]        kmag [3];
  logic [2:0]           kneg;
  logic [KW-1:0]        kmag2 [3];
  logic [2:0]           kneg2;
  logic [LW-1:0]        len;
  logic [KW-1:0]        orv;
  logic [LW-1:0]        lead;
  logic [KW+MW-1:0]     wide [3];
  tun_pkg::flow_t       fl6;
  tun_pkg::flow_t       fl7;
  tun_pkg::flow_t       fl8;
  logic [2*MW-1:0]      sq [3];
  logic [tun_pkg::SUM_W-1:0] ssum;

  always_comb begin
    orv  = kmag[0] | kmag[1] | kmag[2];
    lead = '0;
    for (int b = 0; b < KW; b++) begin
      if (orv[b]) lead = LW'(b + 1);
    end
    for (int j = 0; j < 3; j++) begin
      wide[j] = {kmag2[j], {MW{1'b0}}} >> len;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        crd[i] <= s_tdata[i*W +: W];
      end
      // Edges from the first vertex.
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EW'(crd[3+i]) - EW'(crd[i]);
        e2[i] <= EW'(crd[6+i]) - EW'(crd[i]);
      end
      pr[0] <= e1[1] * e2[2];
      pr[1] <= e1[2] * e2[1];
      pr[2] <= e1[2] * e2[0];
      pr[3] <= e1[0] * e2[2];
      pr[4] <= e1[0] * e2[1];
      pr[5] <= e1[1] * e2[0];
      for (int j = 0; j < 3; j++) begin
        k[j]    <= KW'(pr[2*j]) - KW'(pr[2*j+1]);
        kneg[j] <= k[j][KW-1];
        kmag[j] <= k[j][KW-1] ? KW'(-k[j]) : KW'(k[j]);
      end
      // Hold the magnitudes while the leading bit is found.
      kneg2 <= kneg;
      len   <= lead;
      for (int j = 0; j < 3; j++) begin
        kmag2[j] <= kmag[j];
      end
      // Scale so the largest magnitude lands in [2^30, 2^31).
      fl6.deg <= (len == '0);
      fl6.neg <= kneg2;
      for (int j = 0; j < 3; j++) begin
        fl6.m[j] <= wide[j][MW-1:0];
      end
      fl7 <= fl6;
      for (int j = 0; j < 3; j++) begin
        sq[j] <= fl6.m[j] * fl6.m[j];
      end
      fl8  <= fl7;
      ssum <= tun_pkg::SUM_W'(sq[0]) + tun_pkg::SUM_W'(sq[1]) + tun_pkg::SUM_W'(sq[2]);
    end
  end

  // Square-root chain.
  logic [tun_pkg::SUM_W-1:0]  s_ch    [NSQ+1];
  logic [tun_pkg::SREM_W-1:0] srem_ch [NSQ+1];
  logic [tun_pkg::ROOT_W-1:0] root_ch [NSQ+1];
  tun_pkg::flow_t             sfl_ch  [NSQ+1];

  assign s_ch[0]    = ssum;
  assign srem_ch[0] = '0;
  assign root_ch[0] = '0;
  assign sfl_ch[0]  = fl8;

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk      (clk),
      .en       (en),
      .s_in     (s_ch[g]),
      .rem_in   (srem_ch[g]),
      .root_in  (root_ch[g]),
      .flow_in  (sfl_ch[g]),
      .s_out    (s_ch[g+1]),
      .rem_out  (srem_ch[g+1]),
      .root_out (root_ch[g+1]),
      .flow_out (sfl_ch[g+1])
    );
  end

  // Numerator m*2^F + floor(R/2); its upper bits seed the remainder.
  logic [NW-1:0]                    num [3];
  logic [tun_pkg::ROOT_W-1:0]       droot_ch [QW+1];
  logic [2:0][tun_pkg::ROOT_W-1:0]  drem_ch  [QW+1];
  logic [2:0][F:0]                  dnum_ch  [QW+1];
  logic [2:0][F:0]                  dquo_ch  [QW+1];
  tun_pkg::flow_t                   dfl_ch   [QW+1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num[j] = (NW'(sfl_ch[NSQ].m[j]) << F) + NW'(root_ch[NSQ] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      droot_ch[0] <= root_ch[NSQ];
      dfl_ch[0]   <= sfl_ch[NSQ];
      for (int j = 0; j < 3; j++) begin
        drem_ch[0][j] <= tun_pkg::ROOT_W'(num[j][NW-1:QW]);
        dnum_ch[0][j] <= num[j][QW-1:0];
        dquo_ch[0][j] <= '0;
      end
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    tun_div_cell #(.FRAC(F)) u_cell (
      .clk      (clk),
      .en       (en),
      .root_in  (droot_ch[g]),
      .rem_in   (drem_ch[g]),
      .num_in   (dnum_ch[g]),
      .quo_in   (dquo_ch[g]),
      .flow_in  (dfl_ch[g]),
      .root_out (droot_ch[g+1]),
      .rem_out  (drem_ch[g+1]),
      .num_out  (dnum_ch[g+1]),
      .quo_out  (dquo_ch[g+1]),
      .flow_out (dfl_ch[g+1])
    );
  end

  // Sign and output register.
  logic [2:0][31:0] qv;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qv[j] = 32'(dquo_ch[QW][j]);
      if (dfl_ch[QW].deg) begin
        qv[j] = '0;
      end else if (dfl_ch[QW].neg[j]) begin
        qv[j] = 32'(-qv[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && vld[DEPTH-1]) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[DEPTH-1]) begin
      m_tdata    <= {qv[2], qv[1], qv[0]};
      m_tuser[0] <= dfl_ch[QW].deg;
    end
  end

`ifndef SYNTHESIS
  localparam logic signed [31:0] ONE = 32'sd1 <<< F;

  // A finished result in the last stage reaches the output register.
  a_load: assert property (@(posedge clk) disable iff (rst)
    en && vld[DEPTH-1] |=> m_tvalid)
    else $error("result in last stage not loaded");

  // A degenerate triangle carries a zero normal.
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 96'd0)
    else $error("degenerate result with non-zero normal");

  // Every component of a unit normal lies within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |->
      $signed(m_tdata[31:0]) <= ONE && $signed(m_tdata[31:0]) >= -ONE &&
      $signed(m_tdata[63:32]) <= ONE && $signed(m_tdata[63:32]) >= -ONE &&
      $signed(m_tdata[95:64]) <= ONE && $signed(m_tdata[95:64]) >= -ONE)
    else $error("normal component out of range");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the triangle unit normal pipeline.
`timescale 1ns / 1ps
module tb_top;

  localparam int CW        = 24;
  localparam int NF        = 30;
  localparam int DATA_W    = ((9*CW+7)/8)*8;
  localparam int LATENCY   = 42 + NF + 1;
  localparam int MAX_CYCLE = 600000;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t tri_t [9];

  // One expected normal: three Q2.30 components plus the zero-area flag.
  typedef struct {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic        deg;
  } normal_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [95:0]       m_tdata;
  logic [0:0]        m_tuser;

  normal_t pending_normals[$];
  int      fail_count = 0;
  int      cycle_count = 0;
  bit      idle_enable = 1'b1;  // clear for stretches with no gaps or stalls
  bit      hold_request = 1'b0;

  triangle_unit_normal_core #(
    .COORD_WIDTH      (CW),
    .NORMAL_FRAC_BITS (NF)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop: count every cycle and give up well past the slowest good run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("%0t: timeout with %0d normals outstanding", $time, pending_normals.size());
      $display("triangle_unit_normal_core test failed");
      $finish;
    end
  end

  // Integer square root, floor, by the classic digit-pair method.
  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s   = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Work out the unit normal of one triangle. At CW = 24 the exact cross
  // product needs 51 bits, so plain 64-bit arithmetic holds it exactly.
  function automatic normal_t unit_normal(tri_t v);
    normal_t         n;
    longint          e1 [3];
    longint          e2 [3];
    longint          k  [3];
    longint unsigned mg [3];
    longint unsigned m  [3];
    longint unsigned sum_sq, root, q, signed_q;
    int              lmax, len;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(v[3+i]) - longint'(v[i]);
      e2[i] = longint'(v[6+i]) - longint'(v[i]);
    end
    k[0] = e1[1]*e2[2] - e1[2]*e2[1];
    k[1] = e1[2]*e2[0] - e1[0]*e2[2];
    k[2] = e1[0]*e2[1] - e1[1]*e2[0];
    lmax = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = (k[i] < 0) ? -k[i] : k[i];
      len = 0;
      for (int b = 0; b < 64; b++) if (mg[i][b]) len = b + 1;
      if (len > lmax) lmax = len;
    end
    n.deg = (lmax == 0);
    n.nx = '0;
    n.ny = '0;
    n.nz = '0;
    if (n.deg) return n;
    // Scale so the largest magnitude lands in [2^30, 2^31).
    for (int i = 0; i < 3; i++)
      m[i] = (lmax > 31) ? (mg[i] >> (lmax - 31)) : (mg[i] << (31 - lmax));
    sum_sq = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
    root   = root_floor(sum_sq);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << NF) + (root >> 1)) / root;
      signed_q = (k[i] < 0) ? -q : q;
      if (i == 0) n.nx = signed_q[31:0];
      else if (i == 1) n.ny = signed_q[31:0];
      else n.nz = signed_q[31:0];
    end
    return n;
  endfunction

  // Offer one triangle; returns at the falling edge after its transfer with
  // tvalid still high, so a back-to-back item needs no second assignment.
  task automatic send_triangle(tri_t v);
    int gap;
    gap = idle_enable ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    for (int i = 0; i < 9; i++) s_tdata[i*CW +: CW] <= v[i];
    do @(posedge clk); while (!s_tready);
    pending_normals.push_back(unit_normal(v));
    @(negedge clk);
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_normals.size() != 0) @(negedge clk);
  endtask

  function automatic tri_t random_triangle(int mag_bits);
    tri_t v;
    for (int i = 0; i < 9; i++) begin
      if (mag_bits >= CW) v[i] = coord_t'($urandom());
      else v[i] = coord_t'($signed($urandom_range(0, (1 << mag_bits) - 1)) -
                           (1 << (mag_bits - 1)));
    end
    return v;
  endfunction

  // Receiver: random stall per result, plus one long hold-off on request.
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = idle_enable ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Compare each result transfer with the oldest expected normal.
  always @(posedge clk) begin
    normal_t exp_n;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected result %h deg %b", $time, m_tdata, m_tuser);
        fail_count++;
      end else begin
        exp_n = pending_normals.pop_front();
        if (m_tdata[31:0] !== exp_n.nx) begin
          $display("%0t: normal_x expected %h got %h", $time, exp_n.nx, m_tdata[31:0]);
          fail_count++;
        end
        if (m_tdata[63:32] !== exp_n.ny) begin
          $display("%0t: normal_y expected %h got %h", $time, exp_n.ny, m_tdata[63:32]);
          fail_count++;
        end
        if (m_tdata[95:64] !== exp_n.nz) begin
          $display("%0t: normal_z expected %h got %h", $time, exp_n.nz, m_tdata[95:64]);
          fail_count++;
        end
        if (m_tuser[0] !== exp_n.deg) begin
          $display("%0t: degenerate expected %b got %b", $time, exp_n.deg, m_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // Extreme coordinates, axis-aligned faces and both windings.
  task automatic test_directed();
    tri_t v;
    coord_t cmax, cmin;
    cmax = {1'b0, {(CW-1){1'b1}}};
    cmin = {1'b1, {(CW-1){1'b0}}};
    v = '{cmax, cmax, cmax, cmax, cmax, cmax, cmax, cmax, cmax}; send_triangle(v);
    v = '{cmin, cmin, cmin, cmin, cmin, cmin, cmin, cmin, cmin}; send_triangle(v);
    // Largest edges: widest cross product.
    v = '{cmin, cmin, cmin, cmax, cmin, cmin, cmin, cmax, cmin}; send_triangle(v);
    v = '{cmin, cmin, cmin, cmin, cmax, cmin, cmax, cmin, cmin}; send_triangle(v);
    v = '{cmax, cmin, cmax, cmin, cmax, cmin, cmax, cmax, cmin}; send_triangle(v);
    v = '{cmin, cmax, cmin, cmax, cmin, cmax, cmin, cmin, cmax}; send_triangle(v);
    // Unit triangles in each coordinate plane, both windings in the xy and xz planes.
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_triangle(v);
    v = '{0, 0, 0, 0, 1, 0, 1, 0, 0}; send_triangle(v);
    v = '{0, 0, 0, 0, 1, 0, 0, 0, 1}; send_triangle(v);
    v = '{0, 0, 0, 0, 0, 1, 1, 0, 0}; send_triangle(v);
    v = '{0, 0, 0, 1, 0, 0, 0, 0, 1}; send_triangle(v);
    // Diagonal face with all three components equal, then a unit triangle at negative coordinates.
    v = '{4096, 0, 0, 0, 4096, 0, 0, 0, 4096}; send_triangle(v);
    v = '{-1, -1, -1, 0, -1, -1, -1, 0, -1}; send_triangle(v);
    // Zero area: coincident points and collinear points.
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_triangle(v);
    v = '{cmax, cmin, 5, cmax, cmin, 5, cmax, cmin, 5}; send_triangle(v);
    v = '{1, 2, 3, 2, 4, 6, 3, 6, 9}; send_triangle(v);
    v = '{cmin, cmin, cmin, 0, 0, 0, cmax, cmax, cmax}; send_triangle(v);
    v = '{7, 7, 7, 7, 7, 7, -3, 100, 2}; send_triangle(v);
    wait_drained();
  endtask

  // Random triangles of mixed sizes, with some collinear ones mixed in.
  task automatic test_random(int count);
    tri_t v;
    int   sel, t;
    for (int n = 0; n < count; n++) begin
      if (n % 200 == 0) idle_enable = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        v = random_triangle(CW);
      end else if (sel < 8) begin
        v = random_triangle($urandom_range(2, 12));
      end else if (sel == 8) begin
        // Collinear: C = A + t*(B - A), kept in range by small values.
        v = random_triangle(16);
        t = $urandom_range(0, 6) - 3;
        for (int i = 0; i < 3; i++) v[6+i] = v[i] + coord_t'(t * (v[3+i] - v[i]));
      end else begin
        v = random_triangle(CW);
        for (int i = 0; i < 3; i++) v[3+i] = v[i];
      end
      send_triangle(v);
    end
    idle_enable = 1'b1;
  endtask

  // Hold the output off while items keep coming, so the pipeline fills and
  // the input stalls; then pause the sender until every result is back.
  task automatic test_backpressure();
    hold_request = 1'b1;
    test_random(150);
    wait_drained();
    test_random(40);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1100);
    test_backpressure();
    test_random(150);
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("triangle_unit_normal_core test passed");
    end else begin
      $display("triangle_unit_normal_core test failed");
    end
    $finish;
  end

endmodule
